### hdl/gnms_pkg.sv
package gnms_pkg;

  // gradient sector of a pixel after folding into [0, pi]
  typedef enum logic [1:0] {
    SEC_HORZ    = 2'd0,
    SEC_DIAG45  = 2'd1,
    SEC_VERT    = 2'd2,
    SEC_DIAG135 = 2'd3
  } sector_t;

  // configuration register indexes
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // wide enough for frame limits up to 8192 and the 11-bit registers
  typedef logic [13:0] dim_t;

  localparam int MAG_W = 16;
  localparam int CFG_W = 11;

  // pi and sector bounds in Q3.12
  localparam logic signed [14:0] PI_Q12 = 15'sd12868;
  localparam logic signed [14:0] SEC_B0 = 15'sd1608;
  localparam logic signed [14:0] SEC_B1 = 15'sd4825;
  localparam logic signed [14:0] SEC_B2 = 15'sd8042;
  localparam logic signed [14:0] SEC_B3 = 15'sd11259;

  // one line buffer entry: two rows of magnitudes and the sector of the previous row
  typedef struct packed {
    sector_t          sec;
    logic [MAG_W-1:0] mid;
    logic [MAG_W-1:0] top;
  } line_word_t;

  // pixel travelling from the read stage to the window stage
  typedef struct packed {
    logic             has_result;
    sector_t          sec;
    logic [MAG_W-1:0] mag;
  } stage_t;

endpackage

### hdl/gnms_sector.sv
module gnms_sector (
  input  logic signed [14:0] direction,
  output gnms_pkg::sector_t  sector
);

  logic signed [14:0] d;

  // saturate, fold negative angles by pi, then quantise
  always_comb begin
    d = direction;
    if (d > gnms_pkg::PI_Q12) begin
      d = gnms_pkg::PI_Q12;
    end else if (d < -gnms_pkg::PI_Q12) begin
      d = -gnms_pkg::PI_Q12;
    end
    if (d < 15'sd0) begin
      d = d + gnms_pkg::PI_Q12;
    end
    if (d <= gnms_pkg::SEC_B0) begin
      sector = gnms_pkg::SEC_HORZ;
    end else if (d <= gnms_pkg::SEC_B1) begin
      sector = gnms_pkg::SEC_DIAG45;
    end else if (d <= gnms_pkg::SEC_B2) begin
      sector = gnms_pkg::SEC_VERT;
    end else if (d <= gnms_pkg::SEC_B3) begin
      sector = gnms_pkg::SEC_DIAG135;
    end else begin
      sector = gnms_pkg::SEC_HORZ;
    end
  end

endmodule

### hdl/gnms_line_mem.sv
module gnms_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output gnms_pkg::line_word_t rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  gnms_pkg::line_word_t wr_data
);

  gnms_pkg::line_word_t mem [DEPTH];
  gnms_pkg::line_word_t rd_data_r;

  // registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/gnms_window.sv
module gnms_window (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  gnms_pkg::line_word_t         rd,
  input  logic [gnms_pkg::MAG_W-1:0]   mag,
  output logic [gnms_pkg::MAG_W-1:0]   kept
);

  // left and middle columns of the 3x3 window; rows top, mid, bottom
  logic [gnms_pkg::MAG_W-1:0] win_r [3][2];
  gnms_pkg::sector_t          next_sec_r;
  logic [gnms_pkg::MAG_W-1:0] c, q, p;

  // shift the window left and take the new column
  always_ff @(posedge clk) begin
    if (adv) begin
      win_r[0][0] <= win_r[0][1];
      win_r[0][1] <= rd.top;
      win_r[1][0] <= win_r[1][1];
      win_r[1][1] <= rd.mid;
      win_r[2][0] <= win_r[2][1];
      win_r[2][1] <= mag;
    end
  end

  // sector read one column ahead for the next centre
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_sec_r <= gnms_pkg::SEC_HORZ;
    end else if (adv) begin
      next_sec_r <= rd.sec;
    end
  end

  // neighbours along the centre's sector, taken from the shifted window
  always_comb begin
    c = win_r[1][1];
    case (next_sec_r)
      gnms_pkg::SEC_DIAG45: begin
        q = win_r[2][0];
        p = rd.top;
      end
      gnms_pkg::SEC_VERT: begin
        q = win_r[2][1];
        p = win_r[0][1];
      end
      gnms_pkg::SEC_DIAG135: begin
        q = win_r[0][0];
        p = mag;
      end
      default: begin
        q = rd.mid;
        p = win_r[1][0];
      end
    endcase
    kept = (c >= q && c >= p) ? c : '0;
  end

endmodule

### hdl/gradient_non_maximum_suppression_unit.sv
// Canny non-maximum suppression over a 3x3 window of a gradient stream.
// Input channel: one gradient pixel per transfer in raster order, a 16-bit
// magnitude and a signed Q3.12 direction. Output channel: one transfer per
// interior pixel, with its column, row and the kept magnitude (0 where the
// centre is below a neighbour along its gradient sector). Border pixels give
// no transfer. Frame size is set by cfg writes of width and height, which
// the user must make only while the block is idle (not enforced). Values
// are clamped to 3..MAX_WIDTH/MAX_HEIGHT. Results pass the read stage and
// output register. Throughput: one pixel per clock unless stalled, set by
// the single line buffer memory, read as a pixel is taken and written back
// as it leaves the read stage. A column is revisited no sooner than three
// pixels later, so the read-modify-write never overlaps on one entry.
// Reset clears the position counters, the configuration (both to 1024) and
// all valid flags; no clearing pass is made over the line buffer, whose
// first two rows of each frame are filled before they are used.
// When the receiver stalls, the pending result holds; pixels that give no
// result still pass, and the first one that does waits in the read stage
// while the input is stalled.
module gradient_non_maximum_suppression_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_magnitude,
  input  logic signed [14:0]  in_direction,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [9:0]          out_x,
  output logic [9:0]          out_y,
  output logic [15:0]         out_kept_value,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [10:0]         cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [gnms_pkg::CFG_W-1:0] frame_width_r, frame_height_r;
  gnms_pkg::dim_t             w_lim, h_lim, fw, fh;
  logic [CW-1:0]              col_r, col_nxt, s1_col_r, x_m1;
  logic [RW-1:0]              row_r, row_nxt, s1_row_r, y_m1;
  logic                       in_xfer, s1_valid_r, s1_go;
  gnms_pkg::stage_t           s1_r;
  gnms_pkg::sector_t          in_sec;
  gnms_pkg::line_word_t       rd_data, wr_data;
  logic [15:0]                kept;
  logic                       out_valid_r;
  logic [9:0]                 out_x_r, out_y_r;
  logic [15:0]                out_kept_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 11'd1024;
      frame_height_r <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        gnms_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        gnms_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the frame size to the supported range
  always_comb begin
    fw = gnms_pkg::dim_t'(frame_width_r);
    fh = gnms_pkg::dim_t'(frame_height_r);
    if (fw < gnms_pkg::dim_t'(3)) begin
      w_lim = gnms_pkg::dim_t'(3);
    end else if (fw > gnms_pkg::dim_t'(MAX_WIDTH)) begin
      w_lim = gnms_pkg::dim_t'(MAX_WIDTH);
    end else begin
      w_lim = fw;
    end
    if (fh < gnms_pkg::dim_t'(3)) begin
      h_lim = gnms_pkg::dim_t'(3);
    end else if (fh > gnms_pkg::dim_t'(MAX_HEIGHT)) begin
      h_lim = gnms_pkg::dim_t'(MAX_HEIGHT);
    end else begin
      h_lim = fh;
    end
  end

  // handshake: the read stage moves on unless its result cannot be placed
  assign s1_go    = s1_valid_r && (!s1_r.has_result || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_xfer  = in_valid && !in_stall;

  // position counters with wrap at the frame limits
  always_comb begin
    col_nxt = col_r + 1'b1;
    row_nxt = row_r;
    if (gnms_pkg::dim_t'(col_r) + gnms_pkg::dim_t'(1) >= w_lim) begin
      col_nxt = '0;
      if (gnms_pkg::dim_t'(row_r) + gnms_pkg::dim_t'(1) >= h_lim) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_xfer) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  gnms_sector u_sector (
    .direction (in_direction),
    .sector    (in_sec)
  );

  // read stage: pixel waits here while its line buffer entry is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r.has_result <= (col_r >= CW'(2)) && (row_r >= RW'(2));
      s1_r.sec        <= in_sec;
      s1_r.mag        <= in_magnitude;
      s1_col_r        <= col_r;
      s1_row_r        <= row_r;
    end
  end

  // write back: the row moves up, the new pixel becomes the previous row
  always_comb begin
    wr_data.sec = s1_r.sec;
    wr_data.mid = s1_r.mag;
    wr_data.top = rd_data.mid;
  end

  gnms_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (s1_go),
    .wr_addr (s1_col_r),
    .wr_data (wr_data)
  );

  gnms_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_go),
    .rd    (rd_data),
    .mag   (s1_r.mag),
    .kept  (kept)
  );

  // output register
  assign x_m1 = s1_col_r - 1'b1;
  assign y_m1 = s1_row_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_r.has_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_r.has_result) begin
      out_x_r    <= 10'(x_m1);
      out_y_r    <= 10'(y_m1);
      out_kept_r <= kept;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_kept_value = out_kept_r;

endmodule

### hdl/gnms_checker.sv
module gnms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [9:0]  out_x,
  input logic [9:0]  out_y,
  input logic [15:0] out_kept_value
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_x) && $stable(out_y) && $stable(out_kept_value))
    else $error("result payload changed while stalled");

  // nothing is offered straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // input back-pressure only comes from a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // a fresh result follows an input transfer through the read stage and output register
  a_rose_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching input transfer");

endmodule

bind gradient_non_maximum_suppression_unit gnms_checker u_gnms_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_x          (out_x),
  .out_y          (out_y),
  .out_kept_value (out_kept_value)
);
